// ===== hdl/dpg_pkg.sv =====
// Shared types and constants for the duration parser with running GCD.
// Used by dpg_front, dpg_queue, dpg_back and duration_parse_running_gcd_unit.
package dpg_pkg;

  localparam int AccWidth = 33;
  localparam int ProdWidth = 51;
  localparam int MultWidth = 17;

  localparam logic [AccWidth-1:0] ACC_MAX = 33'h1_FFFF_FFFF;

  localparam logic [1:0] MULT_SEC = 2'd0;
  localparam logic [1:0] MULT_MIN = 2'd1;
  localparam logic [1:0] MULT_HOUR = 2'd2;
  localparam logic [1:0] MULT_DAY = 2'd3;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_BAD_SUFFIX = 2'd1;
  localparam logic [1:0] STATUS_NEGATIVE = 2'd2;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd3;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] CHAR_S = 8'h73;
  localparam logic [7:0] CHAR_M = 8'h6D;
  localparam logic [7:0] CHAR_H = 8'h68;
  localparam logic [7:0] CHAR_D = 8'h64;

  typedef struct packed {
    logic                bad_suffix;
    logic                negative;
    logic [AccWidth-1:0] acc;
    logic [1:0]          mult_sel;
  } dpg_job_t;

  function automatic logic [MultWidth-1:0] mult_value(input logic [1:0] sel);
    logic [MultWidth-1:0] v;
    case (sel)
      MULT_SEC: v = 17'd1;
      MULT_MIN: v = 17'd60;
      MULT_HOUR: v = 17'd3600;
      MULT_DAY: v = 17'd86400;
      default: v = 17'd1;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/dpg_front.sv =====
// Front end: accepts characters, runs the number parser and classifies the suffix.
// Depends on dpg_pkg; hands one job per string to dpg_queue.
module dpg_front import dpg_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     char_in,
  input  logic           is_final,
  input  logic           in_valid,
  output logic           in_ready,
  output dpg_job_t       job,
  output logic           job_valid,
  input  logic           job_ready
);

  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  logic [AccWidth-1:0] acc, acc_next;
  logic [1:0]          phase, phase_next;
  logic                minus, minus_next;

  logic                accept;
  logic                is_ws;
  logic                is_dig;
  logic [3:0]          digit;
  logic [AccWidth+3:0] acc_wide;
  logic [7:0]          lc;

  assign in_ready = job_ready;
  assign accept = in_valid && job_ready;
  assign is_ws = (char_in == CHAR_SPACE) || (char_in >= CHAR_TAB && char_in <= CHAR_CR);
  assign is_dig = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
  assign digit = char_in[3:0];
  assign acc_wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{AccWidth{1'b0}}, digit};

  always_comb begin
    acc_next = acc;
    phase_next = phase;
    minus_next = minus;
    case (phase)
      PH_SKIP: begin
        if (!is_ws) begin
          if (char_in == CHAR_PLUS || char_in == CHAR_MINUS) begin
            minus_next = (char_in == CHAR_MINUS);
            phase_next = PH_DIGITS;
          end else if (is_dig) begin
            acc_next = {{(AccWidth-4){1'b0}}, digit};
            phase_next = PH_DIGITS;
          end else begin
            phase_next = PH_DONE;
          end
        end
      end
      PH_DIGITS: begin
        if (is_dig) begin
          acc_next = (acc_wide > {4'b0, ACC_MAX}) ? ACC_MAX : acc_wide[AccWidth-1:0];
        end else begin
          phase_next = PH_DONE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    lc = (char_in >= CHAR_UPPER_A && char_in <= CHAR_UPPER_Z) ? char_in + CASE_OFFSET : char_in;
    job.acc = acc_next;
    job.negative = minus_next && (acc_next != '0);
    job.bad_suffix = 1'b0;
    job.mult_sel = MULT_SEC;
    if (is_dig || lc == CHAR_S) begin
      job.mult_sel = MULT_SEC;
    end else if (lc == CHAR_M) begin
      job.mult_sel = MULT_MIN;
    end else if (lc == CHAR_H) begin
      job.mult_sel = MULT_HOUR;
    end else if (lc == CHAR_D) begin
      job.mult_sel = MULT_DAY;
    end else begin
      job.bad_suffix = 1'b1;
    end
  end

  assign job_valid = in_valid && is_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      phase <= PH_SKIP;
      minus <= 1'b0;
    end else if (accept) begin
      if (is_final) begin
        acc <= '0;
        phase <= PH_SKIP;
        minus <= 1'b0;
      end else begin
        acc <= acc_next;
        phase <= phase_next;
        minus <= minus_next;
      end
    end
  end

endmodule

// ===== hdl/dpg_queue.sv =====
// Two-entry job queue between the parser front end and the arithmetic back end.
// Depends on dpg_pkg for the job type.
module dpg_queue import dpg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  dpg_job_t push_job,
  input  logic     push_valid,
  output logic     push_ready,
  output dpg_job_t pop_job,
  output logic     pop_valid,
  input  logic     pop_ready
);

  dpg_job_t   slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_job = slots[rptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      case ({do_push, do_pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/dpg_back.sv =====
// Back end: scales the number, checks it and folds it into the running GCD.
// Depends on dpg_pkg; the GCD is a binary (shift and subtract) loop, one step a cycle.
module dpg_back import dpg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dpg_job_t    job,
  input  logic        job_valid,
  output logic        job_ready,
  output logic [1:0]  status,
  output logic [31:0] seconds,
  output logic [31:0] step_gcd,
  output logic        out_valid,
  input  logic        out_ready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_GCD = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]           state;
  dpg_job_t             cur;
  logic [ProdWidth-1:0] prod;
  logic [31:0]          gcd_a;
  logic [31:0]          gcd_b;
  logic [4:0]           shift;
  logic [31:0]          running_gcd;
  logic [1:0]           res_status;
  logic [31:0]          res_secs;
  logic                 emit_fire;

  assign job_ready = (state == S_IDLE);
  assign emit_fire = (state == S_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      running_gcd <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= ProdWidth'(cur.acc) * ProdWidth'(mult_value(cur.mult_sel));
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (cur.bad_suffix) begin
            res_status <= STATUS_BAD_SUFFIX;
            res_secs <= '0;
            state <= S_EMIT;
          end else if (cur.negative) begin
            res_status <= STATUS_NEGATIVE;
            res_secs <= '0;
            state <= S_EMIT;
          end else if (prod[ProdWidth-1:32] != '0) begin
            res_status <= STATUS_TOO_LARGE;
            res_secs <= '0;
            state <= S_EMIT;
          end else begin
            res_status <= STATUS_OK;
            res_secs <= prod[31:0];
            if (prod[31:0] != '0 && running_gcd != '0) begin
              gcd_a <= running_gcd;
              gcd_b <= prod[31:0];
              shift <= '0;
              state <= S_GCD;
            end else begin
              state <= S_EMIT;
              if (prod[31:0] != '0) begin
                running_gcd <= prod[31:0];
              end
            end
          end
        end
        S_GCD: begin
          if (gcd_a == '0) begin
            running_gcd <= gcd_b << shift;
            state <= S_EMIT;
          end else if (!gcd_a[0] && !gcd_b[0]) begin
            gcd_a <= gcd_a >> 1;
            gcd_b <= gcd_b >> 1;
            shift <= shift + 5'd1;
          end else if (!gcd_a[0]) begin
            gcd_a <= gcd_a >> 1;
          end else if (!gcd_b[0]) begin
            gcd_b <= gcd_b >> 1;
          end else if (gcd_a >= gcd_b) begin
            gcd_a <= (gcd_a - gcd_b) >> 1;
          end else begin
            gcd_b <= (gcd_b - gcd_a) >> 1;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      status <= res_status;
      seconds <= res_secs;
      step_gcd <= running_gcd;
    end
  end

endmodule

// ===== hdl/duration_parse_running_gcd_unit.sv =====
// Top level of the duration parser with running GCD: front end, job queue, back end.
// Depends on dpg_pkg, dpg_front, dpg_queue and dpg_back.
//
//   channel | signals                          | word
//   in      | in_valid, in_ready               | char_in, is_final
//   out     | out_valid, out_ready             | status, seconds, step_gcd
//
// Every character is taken in one cycle while the job queue has room.
// With the back end idle, an accepted final character passes the queue, the job capture in
// S_IDLE, S_MUL, S_CHECK and, when needed, the binary GCD loop before S_EMIT registers the
// word; that loop in the back end sets the rate. The queue holds two finished strings.
// Reset clears the parser, the queue, the running GCD and the output valid flag.
module duration_parse_running_gcd_unit import dpg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  char_in,
  input  logic        is_final,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [1:0]  status,
  output logic [31:0] seconds,
  output logic [31:0] step_gcd,
  output logic        out_valid,
  input  logic        out_ready
);

  dpg_job_t front_job;
  logic     front_valid;
  logic     front_ready;
  dpg_job_t back_job;
  logic     back_valid;
  logic     back_ready;

  dpg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .is_final  (is_final),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  dpg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_job    (back_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  dpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .status    (status),
    .seconds   (seconds),
    .step_gcd  (step_gcd),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  a_err_no_seconds: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_OK) |-> (seconds == '0))
    else $error("error word carries nonzero seconds");

  a_ok_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_OK) && (seconds != '0) |-> (step_gcd != '0))
    else $error("accepted nonzero duration left a zero GCD");

  a_gcd_divides_hint: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_OK) && (seconds != '0) |-> (step_gcd <= seconds))
    else $error("GCD exceeds the accepted duration");

endmodule
